@@ hdl/stl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the session table
// Field widths, request codes and the compare unit's result type.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int KEY_W         = 64;
    localparam int TIME_W        = 63;
    localparam int SLOT_W        = 2;
    localparam int DEFAULT_SLOTS = 4;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef struct packed {
        logic key_eq;
        logic stamp_lt;
    } t_cmp_res;

endpackage
`default_nettype wire

@@ hdl/stl_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stl_if: request and response channels of the session table
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface stl_req_if
    import stl_pkg::*;
();
    logic              valid;
    logic              ready;
    t_func             func;
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic              key_well_formed;
    logic [TIME_W-1:0] now;

    modport source (output valid, func, key_high, key_low, key_well_formed, now,
                    input ready);
    modport sink   (input valid, func, key_high, key_low, key_well_formed, now,
                    output ready);
endinterface

interface stl_rsp_if
    import stl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;

    modport source (output valid, hit, slot, evicted, input ready);
    modport sink   (input valid, hit, slot, evicted, output ready);
endinterface
`default_nettype wire

@@ hdl/stl_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stl_mem: key and timestamp storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stl_mem
    import stl_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS,
    parameter int AW    = 2
) (
    input  wire logic                i_clk,
    input  wire logic [AW-1:0]       i_rd_addr,
    output logic      [2*KEY_W-1:0]  o_rd_key,
    output logic      [TIME_W-1:0]   o_rd_stamp,
    input  wire logic [AW-1:0]       i_wr_addr,
    input  wire logic                i_wr_key_en,
    input  wire logic                i_wr_stamp_en,
    input  wire logic [2*KEY_W-1:0]  i_wr_key,
    input  wire logic [TIME_W-1:0]   i_wr_stamp
);

    logic [2*KEY_W-1:0] r_key_mem   [SLOTS];
    logic [TIME_W-1:0]  r_stamp_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_key_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_wr_stamp_en) begin
            r_stamp_mem[i_wr_addr] <= i_wr_stamp;
        end
        o_rd_key   <= r_key_mem[i_rd_addr];
        o_rd_stamp <= r_stamp_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

@@ hdl/stl_cmp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stl_cmp: shared compare unit
// Key equality for lookup and remove, stamp ordering for victim selection.
// ----------------------------------------------------------------------------
module stl_cmp
    import stl_pkg::*;
(
    input  wire logic [2*KEY_W-1:0] i_key_a,
    input  wire logic [2*KEY_W-1:0] i_key_b,
    input  wire logic [TIME_W-1:0]  i_stamp_a,
    input  wire logic [TIME_W-1:0]  i_stamp_b,
    output t_cmp_res                o_res
);

    assign o_res.key_eq   = (i_key_a == i_key_b);
    assign o_res.stamp_lt = (i_stamp_a < i_stamp_b);

endmodule
`default_nettype wire

@@ hdl/session_table_lru_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// session_table_lru_unit: fully associative session table, LRU replacement
// Lookup/touch, insert with oldest-stamp eviction, remove and clear over a
// small table of 128-bit keys, walked one slot per cycle.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake     Payload
//  i_req    in   valid/ready   func, key_high, key_low, key_well_formed, now
//  o_rsp    out  valid/ready   hit, slot, evicted
//
//  A lookup, remove or insert reads one slot per cycle through the storage
//  read port and the shared compare unit; a match or a free slot ends the
//  walk early. The result goes through ST_DONE into the output register,
//  and a new request is taken only once the unit is back in ST_IDLE.
//  Clear and an ill-formed lookup or remove skip the walk and go from the
//  transfer straight to ST_DONE.
//  Reset empties the table at once; keys and stamps are not cleared.
//  A new request is taken while an earlier result waits in the output
//  register; the walk holds its result until that register is free.
// ----------------------------------------------------------------------------
module session_table_lru_unit
    import stl_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stl_req_if.sink    i_req,
    stl_rsp_if.source  o_rsp
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state             r_state, n_state;
    t_func              r_func, n_func;
    logic [2*KEY_W-1:0] r_key, n_key;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [AW-1:0]      r_iss_idx, n_iss_idx;
    logic               r_iss_on, n_iss_on;
    logic [AW-1:0]      r_cmp_idx, n_cmp_idx;
    logic               r_cmp_on, n_cmp_on;
    logic [AW-1:0]      r_best_idx, n_best_idx;
    logic [TIME_W-1:0]  r_best_stamp, n_best_stamp;
    logic [SLOTS-1:0]   r_valid, n_valid;
    logic               r_res_hit, n_res_hit;
    logic [SLOT_W-1:0]  r_res_slot, n_res_slot;
    logic               r_res_evicted, n_res_evicted;
    logic               r_out_vld, n_out_vld;
    logic               r_out_hit, n_out_hit;
    logic [SLOT_W-1:0]  r_out_slot, n_out_slot;
    logic               r_out_evicted, n_out_evicted;

    logic [AW-1:0]      rd_addr;
    logic [2*KEY_W-1:0] rd_key;
    logic [TIME_W-1:0]  rd_stamp;
    logic [AW-1:0]      wr_addr;
    logic               wr_key_en;
    logic               wr_stamp_en;
    t_cmp_res           cmp_res;
    logic               cur_valid;
    logic               take_best;
    logic [AW-1:0]      best_idx_nx;
    logic [AW-1:0]      victim;
    logic               done;
    logic               out_free;

    stl_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk         (i_clk),
        .i_rd_addr     (rd_addr),
        .o_rd_key      (rd_key),
        .o_rd_stamp    (rd_stamp),
        .i_wr_addr     (wr_addr),
        .i_wr_key_en   (wr_key_en),
        .i_wr_stamp_en (wr_stamp_en),
        .i_wr_key      (r_key),
        .i_wr_stamp    (r_now)
    );

    stl_cmp u_cmp (
        .i_key_a   (rd_key),
        .i_key_b   (r_key),
        .i_stamp_a (rd_stamp),
        .i_stamp_b (r_best_stamp),
        .o_res     (cmp_res)
    );

    // slot 0 is read during the request transfer, the rest while scanning
    assign rd_addr   = (r_state == ST_SCAN) ? r_iss_idx : '0;
    assign cur_valid = r_valid[r_cmp_idx];
    assign out_free  = !r_out_vld || o_rsp.ready;

    assign i_req.ready   = (r_state == ST_IDLE);
    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.hit     = r_out_hit;
    assign o_rsp.slot    = r_out_slot;
    assign o_rsp.evicted = r_out_evicted;

    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_key         = r_key;
        n_now         = r_now;
        n_iss_idx     = r_iss_idx;
        n_iss_on      = r_iss_on;
        n_cmp_idx     = r_cmp_idx;
        n_cmp_on      = r_cmp_on;
        n_best_idx    = r_best_idx;
        n_best_stamp  = r_best_stamp;
        n_valid       = r_valid;
        n_res_hit     = r_res_hit;
        n_res_slot    = r_res_slot;
        n_res_evicted = r_res_evicted;
        n_out_vld     = r_out_vld;
        n_out_hit     = r_out_hit;
        n_out_slot    = r_out_slot;
        n_out_evicted = r_out_evicted;
        wr_addr       = r_cmp_idx;
        wr_key_en     = 1'b0;
        wr_stamp_en   = 1'b0;
        take_best     = 1'b0;
        best_idx_nx   = r_best_idx;
        victim        = r_cmp_idx;
        done          = 1'b0;

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_func        = i_req.func;
                    n_key         = {i_req.key_high, i_req.key_low};
                    n_now         = i_req.now;
                    n_res_hit     = 1'b0;
                    n_res_slot    = '0;
                    n_res_evicted = 1'b0;
                    n_cmp_idx     = '0;
                    n_iss_idx     = AW'(1);
                    n_iss_on      = (SLOTS > 1);
                    n_cmp_on      = 1'b0;
                    if (i_req.func == FUNC_CLEAR) begin
                        n_valid = '0;
                        n_state = ST_DONE;
                    end else if (i_req.func != FUNC_INSERT && !i_req.key_well_formed) begin
                        n_state = ST_DONE;
                    end else begin
                        n_cmp_on = 1'b1;
                        n_state  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // advance the read side
                n_cmp_idx = r_iss_idx;
                n_cmp_on  = r_iss_on;
                if (r_iss_on) begin
                    n_iss_idx = r_iss_idx + 1'b1;
                    if (r_iss_idx == LAST) begin
                        n_iss_on = 1'b0;
                    end
                end
                if (r_cmp_on) begin
                    if (r_func == FUNC_INSERT) begin
                        if (!cur_valid) begin
                            victim        = r_cmp_idx;
                            n_res_evicted = 1'b0;
                            done          = 1'b1;
                        end else begin
                            take_best   = (r_cmp_idx == '0) || cmp_res.stamp_lt;
                            best_idx_nx = take_best ? r_cmp_idx : r_best_idx;
                            n_best_idx  = best_idx_nx;
                            if (take_best) begin
                                n_best_stamp = rd_stamp;
                            end
                            if (r_cmp_idx == LAST) begin
                                victim        = best_idx_nx;
                                n_res_evicted = 1'b1;
                                done          = 1'b1;
                            end
                        end
                        if (done) begin
                            wr_addr         = victim;
                            wr_key_en       = 1'b1;
                            wr_stamp_en     = 1'b1;
                            n_valid[victim] = 1'b1;
                            n_res_slot      = SLOT_W'(victim);
                        end
                    end else begin
                        if (cur_valid && cmp_res.key_eq) begin
                            n_res_hit  = 1'b1;
                            n_res_slot = SLOT_W'(r_cmp_idx);
                            done       = 1'b1;
                            if (r_func == FUNC_LOOKUP) begin
                                wr_stamp_en = 1'b1;
                            end else begin
                                n_valid[r_cmp_idx] = 1'b0;
                            end
                        end else if (r_cmp_idx == LAST) begin
                            done = 1'b1;
                        end
                    end
                end
                if (done) begin
                    n_iss_on = 1'b0;
                    n_cmp_on = 1'b0;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    n_out_vld     = 1'b1;
                    n_out_hit     = r_res_hit;
                    n_out_slot    = r_res_slot;
                    n_out_evicted = r_res_evicted;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
            r_iss_on  <= 1'b0;
            r_cmp_on  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_out_vld <= n_out_vld;
            r_iss_on  <= n_iss_on;
            r_cmp_on  <= n_cmp_on;
        end
        r_func        <= n_func;
        r_key         <= n_key;
        r_now         <= n_now;
        r_iss_idx     <= n_iss_idx;
        r_cmp_idx     <= n_cmp_idx;
        r_best_idx    <= n_best_idx;
        r_best_stamp  <= n_best_stamp;
        r_res_hit     <= n_res_hit;
        r_res_slot    <= n_res_slot;
        r_res_evicted <= n_res_evicted;
        r_out_hit     <= n_out_hit;
        r_out_slot    <= n_out_slot;
        r_out_evicted <= n_out_evicted;
    end

endmodule
`default_nettype wire

@@ hdl/stl_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stl_chk: port-level checks of the session table
// Tracks requests in flight against responses seen on the ports.
// ----------------------------------------------------------------------------
module stl_chk
    import stl_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire logic              i_rsp_hit,
    input wire logic [SLOT_W-1:0] i_rsp_slot,
    input wire logic              i_rsp_evicted
);

    logic [2:0] r_pend;
    logic       req_xfer;
    logic       rsp_xfer;

    assign req_xfer = i_req_valid && i_req_ready;
    assign rsp_xfer = i_rsp_valid && i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {2'b00, req_xfer} - {2'b00, rsp_xfer};
        end
    end

    // a response needs a request still in flight
    a_rsp_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (r_pend != 3'd0))
        else $error("response without an outstanding request");

    // one request in work plus one waiting result at most
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 3'd0) || (r_pend == 3'd1) || (r_pend == 3'd2))
        else $error("too many requests in flight");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable({i_rsp_hit, i_rsp_slot, i_rsp_evicted})))
        else $error("stalled response changed");

    a_rst_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_rsp_valid)
        else $error("response valid right after reset");

endmodule

bind session_table_lru_unit stl_chk u_stl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_hit     (o_rsp.hit),
    .i_rsp_slot    (o_rsp.slot),
    .i_rsp_evicted (o_rsp.evicted)
);
`default_nettype wire

@@ tb/session_table_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// session_table_checker: response predictor and scoreboard of the session table
// Mirrors the table on every request transfer and compares each response
// transfer, field by field, against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module session_table_checker
    import stl_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stl_req_if        i_req,
    stl_rsp_if        i_rsp,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
    } t_outcome;

    logic              tbl_valid     [SLOTS];
    logic [KEY_W-1:0]  tbl_key_high  [SLOTS];
    logic [KEY_W-1:0]  tbl_key_low   [SLOTS];
    logic [TIME_W-1:0] tbl_last_used [SLOTS];

    t_outcome outcome_q [$];
    int       fail_count = 0;
    int       pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
        end
    end

    // Apply one request to the mirrored table and return its outcome.
    function automatic t_outcome table_access(input t_func             func,
                                              input logic [KEY_W-1:0]  kh,
                                              input logic [KEY_W-1:0]  kl,
                                              input logic              wf,
                                              input logic [TIME_W-1:0] now);
        t_outcome res;
        int       found;
        int       victim;
        int       oldest;
        res    = '0;
        found  = -1;
        victim = -1;
        oldest = 0;
        case (func)
            FUNC_LOOKUP, FUNC_REMOVE: begin
                if (wf) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (found < 0 && tbl_valid[i] && tbl_key_high[i] == kh &&
                            tbl_key_low[i] == kl) begin
                            found = i;
                        end
                    end
                end
                if (found >= 0) begin
                    res.hit  = 1'b1;
                    res.slot = found[SLOT_W-1:0];
                    if (func == FUNC_LOOKUP) begin
                        tbl_last_used[found] = now;
                    end else begin
                        tbl_valid[found] = 1'b0;
                    end
                end
            end
            FUNC_INSERT: begin
                // first free slot ends the scan; else strictly oldest, low index on ties
                for (int i = 0; i < SLOTS; i++) begin
                    if (victim < 0) begin
                        if (!tbl_valid[i]) begin
                            victim = i;
                        end else if (tbl_last_used[i] < tbl_last_used[oldest]) begin
                            oldest = i;
                        end
                    end
                end
                if (victim < 0) begin
                    victim = oldest;
                end
                res.evicted           = tbl_valid[victim];
                res.slot              = victim[SLOT_W-1:0];
                tbl_valid[victim]     = 1'b1;
                tbl_key_high[victim]  = kh;
                tbl_key_low[victim]   = kl;
                tbl_last_used[victim] = now;
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    tbl_valid[i] = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                tbl_valid[i] = 1'b0;
            end
            outcome_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{hit: i_rsp.hit, slot: i_rsp.slot, evicted: i_rsp.evicted};
                if (outcome_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected response: hit=%0b slot=%0d evicted=%0b",
                                 got.hit, got.slot, got.evicted);
                    end
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("response mismatch: expected hit=%0b slot=%0d %s%0b",
                                     want.hit, want.slot, "evicted=", want.evicted);
                            $display("                   actual   hit=%0b slot=%0d %s%0b",
                                     got.hit, got.slot, "evicted=", got.evicted);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                outcome_q.push_back(table_access(i_req.func, i_req.key_high, i_req.key_low,
                                                 i_req.key_well_formed, i_req.now));
            end
        end
        pending = outcome_q.size();
    end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the session table
// Directed table walks, then random lookup/insert/remove/clear traffic over
// a small key pool under several idle and back-pressure phases.
// ----------------------------------------------------------------------------
module tb_top;
    import stl_pkg::*;

    localparam int SLOTS       = DEFAULT_SLOTS;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_ITEMS  = 1030;
    localparam int POOL_SIZE   = 6;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_phase;

    logic i_clk;
    logic i_rst_n;

    stl_req_if req_if ();
    stl_rsp_if rsp_if ();

    int fail_count;
    int pending;

    session_table_lru_unit #(.SLOTS(SLOTS)) dut (
        .i_clk,
        .i_rst_n,
        .i_req (req_if),
        .o_rsp (rsp_if)
    );

    session_table_checker #(.SLOTS(SLOTS)) table_chk (
        .i_clk,
        .i_rst_n,
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    t_idle_phase       idle_phase = IDLE_NONE;
    int                hold_reqs  = 0;
    int                cycles     = 0;
    logic [KEY_W-1:0]  pool_high [POOL_SIZE];
    logic [KEY_W-1:0]  pool_low  [POOL_SIZE];
    logic [TIME_W-1:0] clock_us   = '0;
    logic [TIME_W-1:0] last_stamp = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int send_idle_pct();
        return (idle_phase == IDLE_SEND) ? 45 : (idle_phase == IDLE_BOTH) ? 35 : 0;
    endfunction

    function automatic int recv_stall_pct();
        return (idle_phase == IDLE_RECV) ? 45 : (idle_phase == IDLE_BOTH) ? 35 : 0;
    endfunction

    // Response side: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        int hold_done;
        hold_left    = 0;
        hold_done    = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                rsp_if.ready = 1'b0;
            end else if (hold_left > 0) begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end else if (hold_reqs != hold_done) begin
                hold_done++;
                hold_left    = LONG_HOLD - 1;
                rsp_if.ready = 1'b0;
            end else begin
                rsp_if.ready = ($urandom_range(99) >= recv_stall_pct());
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the transfer, once any random send idle is over.
    task automatic send_req(input t_func             func,
                            input logic [KEY_W-1:0]  kh,
                            input logic [KEY_W-1:0]  kl,
                            input logic              wf,
                            input logic [TIME_W-1:0] now);
        req_if.valid           = 1'b1;
        req_if.func            = func;
        req_if.key_high        = kh;
        req_if.key_low         = kl;
        req_if.key_well_formed = wf;
        req_if.now             = now;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct()) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    // Hold the request side until every outstanding response has arrived.
    task automatic drain();
        req_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_random();
        int                r;
        int                k;
        t_func             func;
        logic [KEY_W-1:0]  kh;
        logic [KEY_W-1:0]  kl;
        logic              wf;
        logic [TIME_W-1:0] stamp;
        r = $urandom_range(99);
        if (r < 42) begin
            func = FUNC_LOOKUP;
        end else if (r < 72) begin
            func = FUNC_INSERT;
        end else if (r < 97) begin
            func = FUNC_REMOVE;
        end else begin
            func = FUNC_CLEAR;
        end
        k  = $urandom_range(POOL_SIZE - 1);
        kh = pool_high[k];
        kl = pool_low[k];
        r  = $urandom_range(99);
        if (r < 8) begin
            kh = {$urandom, $urandom};
            kl = {$urandom, $urandom};
        end else if (r < 12) begin
            kl = kl ^ (64'd1 << $urandom_range(KEY_W - 1));
        end else if (r < 16) begin
            kh = kh ^ (64'd1 << $urandom_range(KEY_W - 1));
        end
        wf = ($urandom_range(99) >= 8);
        r  = $urandom_range(99);
        if (r < 6) begin
            stamp = TIME_W'({$urandom, $urandom});
        end else if (r < 16) begin
            stamp = last_stamp;  // repeat a stamp to force eviction ties
        end else begin
            clock_us = clock_us + TIME_W'($urandom_range(50, 1));
            stamp    = clock_us;
        end
        last_stamp = stamp;
        send_req(func, kh, kl, wf, stamp);
    endtask

    initial begin
        logic [KEY_W-1:0] ka_h, ka_l, kb_h, kb_l, kc_h, kc_l, kd_h, kd_l, ke_h, ke_l;
        i_rst_n                = 1'b0;
        req_if.valid           = 1'b0;
        req_if.func            = FUNC_LOOKUP;
        req_if.key_high        = '0;
        req_if.key_low         = '0;
        req_if.key_well_formed = 1'b0;
        req_if.now             = '0;

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_high[i] = {$urandom, $urandom};
            pool_low[i]  = {$urandom, $urandom};
        end
        // keys that share one half with another pool key
        pool_high[1] = pool_high[0];
        pool_low[2]  = pool_low[0];

        ka_h = '0;                     ka_l = '0;
        kb_h = '1;                     kb_l = '1;
        kc_h = 64'h0123_4567_89ab_cdef; kc_l = 64'hfedc_ba98_7654_3210;
        kd_h = 64'h0123_4567_89ab_cdef; kd_l = 64'h5555_aaaa_5555_aaaa;
        ke_h = 64'h8000_0000_0000_0001; ke_l = 64'h0000_0001_8000_0000;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table, then fill all slots with edge stamps
        send_req(FUNC_LOOKUP, ka_h, ka_l, 1'b1, 63'd10);
        send_req(FUNC_REMOVE, kb_h, kb_l, 1'b1, 63'd11);
        send_req(FUNC_INSERT, ka_h, ka_l, 1'b1, '0);
        send_req(FUNC_INSERT, kb_h, kb_l, 1'b1, TIME_MAX);
        send_req(FUNC_INSERT, kc_h, kc_l, 1'b1, 63'd5);
        send_req(FUNC_INSERT, kd_h, kd_l, 1'b1, 63'd5);
        // touch, ill-formed miss, unknown key miss
        send_req(FUNC_LOOKUP, ka_h, ka_l, 1'b1, 63'd100);
        send_req(FUNC_LOOKUP, ka_h, ka_l, 1'b0, 63'd101);
        send_req(FUNC_LOOKUP, ke_h, ke_l, 1'b1, 63'd102);
        // full table: stamp tie between two slots, then a duplicate insert
        send_req(FUNC_INSERT, ke_h, ke_l, 1'b0, 63'd200);
        send_req(FUNC_INSERT, kb_h, kb_l, 1'b1, 63'd300);
        send_req(FUNC_LOOKUP, kb_h, kb_l, 1'b1, 63'd400);
        send_req(FUNC_REMOVE, kb_h, kb_l, 1'b0, 63'd401);
        send_req(FUNC_REMOVE, kb_h, kb_l, 1'b1, 63'd402);
        send_req(FUNC_LOOKUP, kb_h, kb_l, 1'b1, 63'd500);
        send_req(FUNC_INSERT, kd_h, kd_l, 1'b1, 63'd600);
        send_req(FUNC_REMOVE, kc_h, kc_l, 1'b1, 63'd601);
        send_req(FUNC_CLEAR,  ka_h, ka_l, 1'b1, TIME_MAX);
        send_req(FUNC_LOOKUP, ka_h, ka_l, 1'b1, 63'd700);
        send_req(FUNC_INSERT, kc_h, kc_l, 1'b0, TIME_MAX);
        send_req(FUNC_INSERT, kd_h, kd_l, 1'b1, '0);
        send_req(FUNC_LOOKUP, kc_h, kd_l, 1'b1, 63'd800);
        send_req(FUNC_CLEAR,  kb_h, kb_l, 1'b0, '0);
        drain();

        for (int p = IDLE_NONE; p <= IDLE_BOTH; p++) begin
            idle_phase <= t_idle_phase'(p);
            @(negedge i_clk);
            if (p == IDLE_NONE) begin
                hold_reqs <= hold_reqs + 1;  // long response hold-off, input backs up
            end
            for (int n = 0; n < RAND_ITEMS / 4; n++) begin
                send_random();
                if (p == IDLE_SEND && n == RAND_ITEMS / 8) begin
                    drain();
                end
            end
            drain();
        end

        drain();
        repeat (SLOTS + 10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ session_table_lru_unit.f @@
hdl/stl_pkg.sv
hdl/stl_if.sv
hdl/stl_mem.sv
hdl/stl_cmp.sv
hdl/session_table_lru_unit.sv
hdl/stl_chk.sv
tb/session_table_checker.sv
tb/tb_top.sv
